### src/byte_stack_with_multi_pop_unit_defines.svh
// Assertion macros used by the byte stack top level.
`ifndef BYTE_STACK_WITH_MULTI_POP_UNIT_DEFINES_SVH
`define BYTE_STACK_WITH_MULTI_POP_UNIT_DEFINES_SVH

// Check that expr holds in the same cycle whenever cond holds.
`define BSTK_ASSERT_SAME(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check that expr holds in the cycle after cond holds.
`define BSTK_ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### src/bstk_pkg.sv
// Types and codes used by the byte stack top level.
package bstk_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int BYTE_W              = 8;
    localparam int FILL_W              = 7;
    localparam int CMD_W               = 3;
    localparam int STATUS_W            = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK_N = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_N  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEG_CNT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CNT_BIG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [BYTE_W-1:0]        push_byte;
        logic signed [BYTE_W-1:0] count;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic                byte_valid;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_level;
        logic                empty_flag;
        logic                last;
    } t_out_word;

endpackage

### src/byte_stack_with_multi_pop_unit.sv
// Byte stack (LIFO) with single and multi-element peek and pop, top level.
//
// Input channel (i_in_valid / o_in_stall / i_in_word): one word per command:
// push, pop, peek top, peek top N, pop top N. Output channel (o_out_valid /
// i_out_stall / o_out_word): one result word per push, single pop or peek,
// error or zero count; N words for a multi peek or pop, deepest element
// first, the final word marked with last. Every word reports the fill level
// after its command and an empty flag.
// Timing: push, error and zero-count results show in the cycle after the
// command is taken; results that read the stack memory pass through the
// synchronous memory read and then the output register. Pushes go back to
// back while the receiver does not stall, and so do pops and peeks; a command
// that needs no read waits while a read result is pending. A multi-element
// command reads one element at a time through the single memory read port.
// The read data register of the memory acts as a holding stage, so a stalled
// receiver lets one more reading command in before o_in_stall rises.
// Reset (synchronous, active low) empties the stack and drops any result in
// flight; the memory itself is not cleared, only entries below the fill
// level are ever read. While the receiver stalls, the output word holds.
module byte_stack_with_multi_pop_unit #(
    parameter int STACK_DEPTH = bstk_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bstk_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bstk_pkg::t_out_word o_out_word
);

    `include "byte_stack_with_multi_pop_unit_defines.svh"

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int NW = bstk_pkg::BYTE_W - 1;           // magnitude of count
    localparam int XW = PW + NW;                         // compare width
    localparam logic [PW-1:0] FULL_LVL = PW'(STACK_DEPTH);

    // Control state
    logic [PW-1:0] r_fill;     // stack pointer: number of elements held
    logic          r_busy;     // streaming the rest of a multi command
    logic [AW-1:0] r_addr;     // next address to read while streaming
    logic [NW-1:0] r_remain;   // reads left while streaming
    logic [PW-1:0] r_mfill;    // fill level reported by the multi command
    logic          r_pend;     // memory read data waits for the output
    logic          r_pend_last;
    logic [PW-1:0] r_pend_fill;
    logic          r_ov;
    bstk_pkg::t_out_word r_out;

    // Next values
    logic          n_busy;
    logic [AW-1:0] n_addr;
    logic [NW-1:0] n_remain;
    logic [PW-1:0] n_mfill;
    logic [PW-1:0] n_fill;
    logic          n_pend;
    logic          n_pend_last;
    logic [PW-1:0] n_pend_fill;
    logic          n_ov;
    bstk_pkg::t_out_word n_out;

    // Decode
    logic                  is_push, is_single, is_multi, is_pop_kind;
    logic                  neg, too_big, n_zero, st_empty, st_full;
    logic [NW-1:0]         cnt_n;
    logic [XW-1:0]         top_x, cnt_x, diff_x;
    logic [PW-1:0]         base, top_m1;
    logic                  needs_read, in_ready, in_acc;
    logic                  slot_free, pend_go, rd_ok, imm_load;
    logic [bstk_pkg::STATUS_W-1:0] imm_status;
    logic [PW-1:0]         imm_fill;
    logic [PW+bstk_pkg::FILL_W-1:0] pend_fill_x, imm_fill_x;

    // Memory port
    logic                      ram_we, ram_re;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [bstk_pkg::BYTE_W-1:0] ram_rdata;

    always_comb begin
        is_push     = (i_in_word.command == bstk_pkg::CMD_PUSH);
        is_single   = (i_in_word.command == bstk_pkg::CMD_POP) ||
                      (i_in_word.command == bstk_pkg::CMD_PEEK);
        is_multi    = (i_in_word.command == bstk_pkg::CMD_PEEK_N) ||
                      (i_in_word.command == bstk_pkg::CMD_POP_N);
        is_pop_kind = (i_in_word.command == bstk_pkg::CMD_POP) ||
                      (i_in_word.command == bstk_pkg::CMD_POP_N);
        neg         = i_in_word.count[bstk_pkg::BYTE_W-1];
        cnt_n       = i_in_word.count[NW-1:0];
        n_zero      = (cnt_n == '0);
        st_empty    = (r_fill == '0);
        st_full     = (r_fill == FULL_LVL);
        top_x       = {{NW{1'b0}}, r_fill};
        cnt_x       = {{PW{1'b0}}, cnt_n};
        too_big     = (cnt_x > top_x);
        diff_x      = top_x - cnt_x;
        base        = diff_x[PW-1:0];
        top_m1      = r_fill - PW'(1);
        needs_read  = (is_single && !st_empty) ||
                      (is_multi && !neg && !too_big && !n_zero);

        // Output register loads when empty or being taken this cycle.
        slot_free = !r_ov || !i_out_stall;
        pend_go   = r_pend && slot_free;
        rd_ok     = !r_pend || pend_go;
        in_ready  = !r_busy && (needs_read ? rd_ok : (!r_pend && slot_free));
        in_acc    = i_in_valid && in_ready;
        imm_load  = in_acc && !needs_read;

        priority if (is_push) begin
            imm_status = st_full ? bstk_pkg::ST_FULL : bstk_pkg::ST_OK;
        end else if (is_single) begin
            imm_status = bstk_pkg::ST_EMPTY;
        end else if (is_multi && neg) begin
            imm_status = bstk_pkg::ST_NEG_CNT;
        end else if (is_multi && too_big) begin
            imm_status = bstk_pkg::ST_CNT_BIG;
        end else begin
            imm_status = bstk_pkg::ST_OK;
        end
        imm_fill = (is_push && !st_full) ? r_fill + PW'(1) : r_fill;
    end

    always_comb begin
        n_busy      = r_busy;
        n_addr      = r_addr;
        n_remain    = r_remain;
        n_mfill     = r_mfill;
        n_fill      = r_fill;
        n_pend      = pend_go ? 1'b0 : r_pend;
        n_pend_last = r_pend_last;
        n_pend_fill = r_pend_fill;
        ram_we      = 1'b0;
        ram_waddr   = r_fill[AW-1:0];
        ram_re      = 1'b0;
        ram_raddr   = r_addr;

        if (r_busy) begin
            // Stream the next element once the read register frees up.
            if (rd_ok) begin
                ram_re      = 1'b1;
                n_addr      = r_addr + AW'(1);
                n_remain    = r_remain - NW'(1);
                n_pend      = 1'b1;
                n_pend_last = (r_remain == NW'(1));
                n_pend_fill = r_mfill;
                n_busy      = (r_remain != NW'(1));
            end
        end else if (in_acc) begin
            if (is_push && !st_full) begin
                ram_we = 1'b1;
                n_fill = r_fill + PW'(1);
            end
            if (needs_read) begin
                ram_re = 1'b1;
                n_pend = 1'b1;
                if (is_single) begin
                    ram_raddr   = top_m1[AW-1:0];
                    n_pend_last = 1'b1;
                    n_pend_fill = is_pop_kind ? top_m1 : r_fill;
                    n_fill      = is_pop_kind ? top_m1 : r_fill;
                end else begin
                    // Deepest of the N first; the pointer drops at once on pop.
                    ram_raddr   = base[AW-1:0];
                    n_pend_last = (cnt_n == NW'(1));
                    n_pend_fill = is_pop_kind ? base : r_fill;
                    n_fill      = is_pop_kind ? base : r_fill;
                    n_mfill     = is_pop_kind ? base : r_fill;
                    n_addr      = base[AW-1:0] + AW'(1);
                    n_remain    = cnt_n - NW'(1);
                    n_busy      = (cnt_n != NW'(1));
                end
            end
        end
    end

    // Output word assembly
    always_comb begin
        pend_fill_x = {{bstk_pkg::FILL_W{1'b0}}, r_pend_fill};
        imm_fill_x  = {{bstk_pkg::FILL_W{1'b0}}, imm_fill};
        n_out       = r_out;
        n_ov        = r_ov && i_out_stall;
        if (pend_go) begin
            n_ov             = 1'b1;
            n_out.out_byte   = ram_rdata;
            n_out.byte_valid = 1'b1;
            n_out.status     = bstk_pkg::ST_OK;
            n_out.fill_level = pend_fill_x[bstk_pkg::FILL_W-1:0];
            n_out.empty_flag = (r_pend_fill == '0);
            n_out.last       = r_pend_last;
        end else if (imm_load) begin
            n_ov             = 1'b1;
            n_out.out_byte   = '0;
            n_out.byte_valid = 1'b0;
            n_out.status     = imm_status;
            n_out.fill_level = imm_fill_x[bstk_pkg::FILL_W-1:0];
            n_out.empty_flag = (imm_fill == '0);
            n_out.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_busy <= n_busy;
            r_pend <= n_pend;
            r_ov   <= n_ov;
        end
        r_addr      <= n_addr;
        r_remain    <= n_remain;
        r_mfill     <= n_mfill;
        r_pend_last <= n_pend_last;
        r_pend_fill <= n_pend_fill;
        r_out       <= n_out;
    end

    // A push writes at the edge that takes it, so a read issued by a later
    // command always sees the stored byte: no forwarding is needed.
    bstk_ram #(
        .WIDTH (bstk_pkg::BYTE_W),
        .DEPTH (STACK_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_word.push_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    `BSTK_ASSERT_SAME(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FULL_LVL,
        "fill level above stack depth")
    `BSTK_ASSERT_SAME(a_busy_remain, i_clk, i_rst_n, r_busy, r_remain != '0,
        "streaming with no reads left")
    `BSTK_ASSERT_SAME(a_one_load, i_clk, i_rst_n, pend_go, !imm_load,
        "two results loaded into the output register at once")
    `BSTK_ASSERT_NEXT(a_push_grow, i_clk, i_rst_n, in_acc && is_push && !st_full,
        r_fill == $past(r_fill) + PW'(1), "push did not raise the fill level")

endmodule

### src/bstk_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
module bstk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Hold read data until the next read.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
